@@ design/pcfl_pkg.sv @@
// ----------------------------------------------------------------------------
// pcfl_pkg: shared types, constants and step functions
// Holds the pipeline word layout, register codes and the arithmetic steps
// that several stages of the friction pipeline reuse.
// ----------------------------------------------------------------------------
package pcfl_pkg;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MU_STICK  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MU_SLIDE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAN_RATIO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 8'd3;

    localparam logic [15:0] RATIO_RESET = 16'd256;
    localparam logic [31:0] STEP_RESET  = 32'd16777;

    // 0.1*log2(e) and ln(2) in Q0.32, epsilon squared in Q18.46.
    localparam logic [31:0] DECAY_LOG2E = 32'd619632802;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [63:0] EPS_SQ      = 64'd7036874418;

    localparam int FRONT_STAGES = 33;
    localparam int DECAY_STAGES = 36;
    localparam int REGUL_STAGES = 66;
    localparam int BACK_STAGES  = 4;

    typedef struct packed {
        logic [15:0] mu_stick;
        logic [15:0] mu_slide;
        logic [15:0] ratio;
        logic [31:0] step_time;
    } cfg_t;

    // One contact point as it travels down the pipeline.
    typedef struct packed {
        logic        gn_neg;
        logic        gt_neg;
        logic [31:0] gt_mag;
        logic [47:0] nfp;
        logic [39:0] pt;
        logic [31:0] nf_bits;
        logic [31:0] nf_mag;
        logic [56:0] trial;
        logic [31:0] den;
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic        ovf;
        logic        cap;
        logic [31:0] vel;
        logic [15:0] f;
        logic        nbig;
        logic [5:0]  nsh;
        logic [31:0] t;
        logic [31:0] term;
        logic [31:0] p;
        logic [31:0] q0;
        logic [34:0] sum;
        logic [32:0] d;
        logic        byp;
        logic [30:0] w;
        logic [63:0] sx;
        logic [63:0] sres;
        logic [32:0] r;
        logic [31:0] mr;
        logic [15:0] fc;
        logic [35:0] limit;
        logic [31:0] tf;
        logic        slip;
    } item_t;

    function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
        logic [31:0] res;
        if (neg) begin
            if (mag >= 64'h8000_0000) res = 32'h8000_0000;
            else res = ~mag[31:0] + 32'd1;
        end else begin
            if (mag > 64'h7FFF_FFFF) res = 32'h7FFF_FFFF;
            else res = mag[31:0];
        end
        return res;
    endfunction

    // One restoring division step: one quotient bit per call.
    function automatic item_t div_step(input item_t it);
        item_t       o;
        logic [32:0] part;
        logic        qb;
        o    = it;
        part = {it.rem, it.num[31]};
        qb   = (part >= {1'b0, it.den});
        o.rem = qb ? 32'(part - {1'b0, it.den}) : part[31:0];
        o.num = {it.num[30:0], 1'b0};
        o.quo = {it.quo[30:0], qb};
        return o;
    endfunction

    // One digit-by-digit square root step for the given bit weight.
    function automatic item_t sqrt_step(input item_t it, input logic [63:0] bitv);
        item_t       o;
        logic [63:0] trial_v;
        o       = it;
        trial_v = it.sres + bitv;
        if (it.sx >= trial_v) begin
            o.sx   = it.sx - trial_v;
            o.sres = (it.sres >> 1) + bitv;
        end else begin
            o.sres = it.sres >> 1;
        end
        return o;
    endfunction

endpackage

@@ design/pcfl_front.sv @@
// ----------------------------------------------------------------------------
// pcfl_front: input stage, normal force and sliding velocity divider
// Takes the gaps apart into sign and magnitude, forms the normal force and
// the trial tangent force, and divides the tangent gap by the time step.
// ----------------------------------------------------------------------------
module pcfl_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                i_valid,
    input  logic [31:0]         i_gap_normal,
    input  logic [31:0]         i_gap_tangent,
    input  logic [31:0]         i_penalty_normal,
    input  pcfl_pkg::cfg_t      cfg,
    output logic                o_valid,
    output pcfl_pkg::item_t     o_item
);
    import pcfl_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;
    item_t                   pipe_reg   [FRONT_STAGES];
    item_t                   stage_next [FRONT_STAGES];
    logic [31:0]             gn_mag;
    logic [31:0]             dt;
    logic [63:0]             nf_prod;
    logic [47:0]             pt_prod;

    always_comb begin
        stage_next[0]        = '0;
        stage_next[0].gn_neg = i_gap_normal[31];
        stage_next[0].gt_neg = i_gap_tangent[31];
        gn_mag = i_gap_normal[31] ? (~i_gap_normal + 32'd1) : i_gap_normal;
        stage_next[0].gt_mag = i_gap_tangent[31] ? (~i_gap_tangent + 32'd1) : i_gap_tangent;
        nf_prod = 64'(gn_mag) * 64'(i_penalty_normal);
        stage_next[0].nfp = nf_prod[63:16];
        pt_prod = 48'(i_penalty_normal) * 48'(cfg.ratio);
        stage_next[0].pt = pt_prod[47:8];
        dt = (cfg.step_time == '0) ? 32'd1 : cfg.step_time;
        stage_next[0].den = dt;
        // A quotient of 2^32 or more saturates the velocity.
        stage_next[0].ovf = ({8'd0, stage_next[0].gt_mag} >= {dt, 8'd0});
        stage_next[0].rem = {8'd0, stage_next[0].gt_mag[31:8]};
        stage_next[0].num = {stage_next[0].gt_mag[7:0], 24'd0};
    end

    for (genvar gi = 1; gi < FRONT_STAGES; gi++) begin : g_st
        item_t       tmp;
        logic [55:0] th;
        logic [55:0] tl;
        always_comb begin
            tmp = div_step(pipe_reg[gi-1]);
            th  = 56'(pipe_reg[gi-1].pt) * 56'(pipe_reg[gi-1].gt_mag[31:16]);
            tl  = 56'(pipe_reg[gi-1].pt) * 56'(pipe_reg[gi-1].gt_mag[15:0]);
            if (gi == 1) begin
                tmp.nf_bits = sat32(pipe_reg[gi-1].gn_neg, {16'd0, pipe_reg[gi-1].nfp});
                tmp.nf_mag  = tmp.nf_bits[31] ? (~tmp.nf_bits + 32'd1) : tmp.nf_bits;
                tmp.trial   = 57'(th) + 57'(tl >> 16);
            end
            stage_next[gi] = tmp;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < FRONT_STAGES; i++) pipe_reg[i] <= stage_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = vld_reg[FRONT_STAGES-1];
    assign o_item  = pipe_reg[FRONT_STAGES-1];

endmodule

@@ design/pcfl_decay.sv @@
// ----------------------------------------------------------------------------
// pcfl_decay: exponential decay of the friction coefficient
// Splits -0.1*|v| into a power of two and a fraction, sums a twelve term
// series for the fraction and shifts by the integer part.
// ----------------------------------------------------------------------------
module pcfl_decay (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                i_valid,
    input  pcfl_pkg::item_t     i_item,
    output logic                o_valid,
    output pcfl_pkg::item_t     o_item
);
    import pcfl_pkg::*;

    logic [DECAY_STAGES-1:0] vld_reg;
    item_t                   pipe_reg   [DECAY_STAGES];
    item_t                   stage_next [DECAY_STAGES];
    logic [63:0]             yp;
    logic [15:0]             n_int;

    always_comb begin
        stage_next[0]     = i_item;
        stage_next[0].vel = i_item.ovf ? 32'hFFFF_FFFF : i_item.quo;
        yp    = 64'(stage_next[0].vel) * 64'(DECAY_LOG2E);
        n_int = yp[63:48];
        stage_next[0].f    = yp[47:32];
        stage_next[0].nbig = (n_int > 16'd32);
        stage_next[0].nsh  = n_int[5:0];
    end

    for (genvar gi = 1; gi < DECAY_STAGES; gi++) begin : g_st
        if (gi == 1) begin : g_first
            logic [47:0] tp;
            always_comb begin
                stage_next[gi] = pipe_reg[gi-1];
                tp = 48'(pipe_reg[gi-1].f) * 48'(LN2_Q32);
                stage_next[gi].t    = tp[47:16];
                stage_next[gi].term = tp[47:16];
                stage_next[gi].sum  = 35'(33'h1_0000_0000 - {1'b0, tp[47:16]});
            end
        end else if (gi < DECAY_STAGES - 1) begin : g_term
            localparam int          K  = (gi - 2) / 3 + 2;
            localparam int          PH = (gi - 2) % 3;
            localparam logic [35:0] MK = 36'((64'd1 << 36) / K);
            logic [63:0] pp;
            logic [67:0] qp;
            logic [35:0] diff;
            logic [31:0] q;
            always_comb begin
                stage_next[gi] = pipe_reg[gi-1];
                pp   = 64'(pipe_reg[gi-1].term) * 64'(pipe_reg[gi-1].t);
                qp   = 68'(pipe_reg[gi-1].p) * 68'(MK);
                // The reciprocal estimate is low by at most one.
                diff = 36'(pipe_reg[gi-1].p) - 36'(pipe_reg[gi-1].q0) * 36'(K);
                q    = pipe_reg[gi-1].q0 + 32'(diff >= 36'(K));
                if (PH == 0) begin
                    stage_next[gi].p = pp[63:32];
                end else if (PH == 1) begin
                    stage_next[gi].q0 = qp[67:36];
                end else begin
                    stage_next[gi].term = q;
                    if (K % 2 == 1) stage_next[gi].sum = pipe_reg[gi-1].sum - 35'(q);
                    else stage_next[gi].sum = pipe_reg[gi-1].sum + 35'(q);
                end
            end
        end else begin : g_last
            logic [32:0] clamped;
            always_comb begin
                stage_next[gi] = pipe_reg[gi-1];
                clamped = pipe_reg[gi-1].sum[34] ? 33'd0 : pipe_reg[gi-1].sum[32:0];
                stage_next[gi].d = pipe_reg[gi-1].nbig ? 33'd0 : (clamped >> pipe_reg[gi-1].nsh);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DECAY_STAGES; i++) pipe_reg[i] <= stage_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DECAY_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = vld_reg[DECAY_STAGES-1];
    assign o_item  = pipe_reg[DECAY_STAGES-1];

endmodule

@@ design/pcfl_regul.sv @@
// ----------------------------------------------------------------------------
// pcfl_regul: velocity regularization |v|/sqrt(v^2+E^2)
// A pipelined square root followed by a pipelined divider, one result bit
// per stage in each.
// ----------------------------------------------------------------------------
module pcfl_regul (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                i_valid,
    input  pcfl_pkg::item_t     i_item,
    output logic                o_valid,
    output pcfl_pkg::item_t     o_item
);
    import pcfl_pkg::*;

    localparam int SQRT_LAST = 32;

    logic [REGUL_STAGES-1:0] vld_reg;
    item_t                   pipe_reg   [REGUL_STAGES];
    item_t                   stage_next [REGUL_STAGES];

    always_comb begin
        stage_next[0]      = i_item;
        stage_next[0].byp  = |i_item.vel[31:24];
        stage_next[0].w    = {i_item.vel[23:0], 7'd0};
        stage_next[0].sx   = 64'(stage_next[0].w) * 64'(stage_next[0].w) + EPS_SQ;
        stage_next[0].sres = '0;
    end

    for (genvar gi = 1; gi < REGUL_STAGES; gi++) begin : g_st
        if (gi <= SQRT_LAST) begin : g_sqrt
            localparam logic [63:0] BITV = 64'd1 << (62 - 2 * (gi - 1));
            always_comb stage_next[gi] = sqrt_step(pipe_reg[gi-1], BITV);
        end else if (gi == SQRT_LAST + 1) begin : g_init
            logic [31:0] root;
            always_comb begin
                stage_next[gi] = pipe_reg[gi-1];
                root = (pipe_reg[gi-1].sres[31:0] == '0) ? 32'd1 : pipe_reg[gi-1].sres[31:0];
                // w >= root means the ratio reaches one and is capped there.
                stage_next[gi].cap = ({1'b0, pipe_reg[gi-1].w} >= root);
                stage_next[gi].rem = {1'b0, pipe_reg[gi-1].w};
                stage_next[gi].num = '0;
                stage_next[gi].quo = '0;
                stage_next[gi].den = root;
            end
        end else begin : g_div
            always_comb stage_next[gi] = div_step(pipe_reg[gi-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < REGUL_STAGES; i++) pipe_reg[i] <= stage_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[REGUL_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = vld_reg[REGUL_STAGES-1];
    assign o_item  = pipe_reg[REGUL_STAGES-1];

endmodule

@@ design/pcfl_back.sv @@
// ----------------------------------------------------------------------------
// pcfl_back: friction coefficient, Coulomb limit and clip
// Blends static and dynamic coefficients, applies the regularization, and
// clips the trial tangent force; the last stage is the output register.
// ----------------------------------------------------------------------------
module pcfl_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                i_valid,
    input  pcfl_pkg::item_t     i_item,
    input  pcfl_pkg::cfg_t      cfg,
    output logic                o_valid,
    output pcfl_pkg::item_t     o_item
);
    import pcfl_pkg::*;

    logic [BACK_STAGES-1:0] vld_reg;
    item_t                  pipe_reg   [BACK_STAGES];
    item_t                  stage_next [BACK_STAGES];
    logic signed [16:0]     mu_diff;
    logic signed [50:0]     mu_s;
    logic [64:0]            fp;
    logic [47:0]            lp;
    logic                   slip;

    always_comb begin
        stage_next[0]   = i_item;
        stage_next[0].r = (i_item.byp || i_item.cap) ? 33'h1_0000_0000 : {1'b0, i_item.quo};
        mu_diff = $signed({1'b0, cfg.mu_stick}) - $signed({1'b0, cfg.mu_slide});
        mu_s    = $signed({3'b0, cfg.mu_slide, 32'd0}) + mu_diff * $signed({1'b0, i_item.d});
        stage_next[0].mr = mu_s[50] ? 32'd0 : mu_s[47:16];

        stage_next[1]    = pipe_reg[0];
        fp = 65'(pipe_reg[0].mr) * 65'(pipe_reg[0].r);
        stage_next[1].fc = fp[64] ? 16'hFFFF : fp[63:48];

        stage_next[2]       = pipe_reg[1];
        lp = 48'(pipe_reg[1].fc) * 48'(pipe_reg[1].nf_mag);
        stage_next[2].limit = lp[47:12];

        stage_next[3]      = pipe_reg[2];
        slip = pipe_reg[2].trial > 57'(pipe_reg[2].limit);
        stage_next[3].slip = slip;
        stage_next[3].tf   = sat32(pipe_reg[2].gt_neg,
                                   slip ? 64'(pipe_reg[2].limit) : 64'(pipe_reg[2].trial));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < BACK_STAGES; i++) pipe_reg[i] <= stage_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[BACK_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = vld_reg[BACK_STAGES-1];
    assign o_item  = pipe_reg[BACK_STAGES-1];

endmodule

@@ design/penalty_contact_friction_law.sv @@
// ----------------------------------------------------------------------------
// penalty_contact_friction_law: penalty contact with regularized friction
// Normal force, Stribeck-style friction coefficient and Coulomb clip of the
// tangent force for one contact point per word.
//
//   channel   dir   width        contents
//   s_*       in    96 + hs      gap_normal, gap_tangent, penalty_normal
//   m_*       out   80 + 1 + hs  normal_force, tangent_force, friction_coeff; slip
//   cfg_*     in    8 + 32 + hs  register index and write data
//
// One word is accepted per cycle while the output is taken; each result
// passes through the velocity divider, the square root and the
// regularization divider, which resolve one bit per stage.
// Reset clears the valid bits and loads the register reset values.
// When the output word is not taken the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module penalty_contact_friction_law (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // gap_normal [31:0], gap_tangent [63:32], penalty_normal [95:64]
    input  logic [pcfl_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // normal_force [31:0], tangent_force [63:32], friction_coeff [79:64]
    output logic [pcfl_pkg::OUT_DATA_W-1:0] m_tdata,
    // slip [0]
    output logic                          m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pcfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                   cfg_data
);
    import pcfl_pkg::*;

    logic [15:0] mu_stick_reg;
    logic [15:0] mu_slide_reg;
    logic [15:0] ratio_reg;
    logic [31:0] step_time_reg;
    cfg_t        cfg;
    logic        en;
    logic        front_valid;
    logic        decay_valid;
    logic        regul_valid;
    item_t       front_item;
    item_t       decay_item;
    item_t       regul_item;
    item_t       out_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_stick_reg  <= '0;
            mu_slide_reg  <= '0;
            ratio_reg     <= RATIO_RESET;
            step_time_reg <= STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MU_STICK:  mu_stick_reg  <= cfg_data[15:0];
                CFG_MU_SLIDE:  mu_slide_reg  <= cfg_data[15:0];
                CFG_TAN_RATIO: ratio_reg     <= cfg_data[15:0];
                CFG_STEP_TIME: step_time_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.mu_stick  = mu_stick_reg;
    assign cfg.mu_slide  = mu_slide_reg;
    assign cfg.ratio     = ratio_reg;
    assign cfg.step_time = step_time_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    pcfl_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .i_valid          (s_tvalid),
        .i_gap_normal     (s_tdata[31:0]),
        .i_gap_tangent    (s_tdata[63:32]),
        .i_penalty_normal (s_tdata[95:64]),
        .cfg              (cfg),
        .o_valid          (front_valid),
        .o_item           (front_item)
    );

    pcfl_decay u_decay (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_valid (decay_valid),
        .o_item  (decay_item)
    );

    pcfl_regul u_regul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (decay_valid),
        .i_item  (decay_item),
        .o_valid (regul_valid),
        .o_item  (regul_item)
    );

    pcfl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .i_valid (regul_valid),
        .i_item  (regul_item),
        .cfg     (cfg),
        .o_valid (m_tvalid),
        .o_item  (out_item)
    );

    assign m_tdata = {out_item.fc, out_item.tf, out_item.nf_bits};
    assign m_tuser = out_item.slip;

    // A slipping contact was clipped because the trial force beat the limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_item.slip) |-> (57'(out_item.limit) < out_item.trial))
        else $error("slip raised without the trial force exceeding the limit");

    // At rest the regularization drives the coefficient to zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_item.vel == '0)) |-> (out_item.fc == '0))
        else $error("nonzero friction coefficient at zero sliding velocity");

    // The decay factor never rises above one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_item.d <= 33'h1_0000_0000))
        else $error("decay factor above one");

endmodule
